// ===== src/migp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// migp_pkg
// Shared types, constants and lookup functions of the metering group parser.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
package migp_pkg;

   localparam int MAX_LABEL_CHARS = 8;
   localparam int MAX_DATA_CHARS  = 12;
   localparam int HEAD_LEN        = 4;
   localparam int VAL_W           = 40;

   localparam int LBL_CNT_W = $clog2(MAX_LABEL_CHARS + 1);
   localparam int LBL_IDX_W = (MAX_LABEL_CHARS > 1) ? $clog2(MAX_LABEL_CHARS) : 1;
   localparam int DAT_CNT_W = $clog2(MAX_DATA_CHARS + 1);
   localparam int LBL_CMP   = (MAX_LABEL_CHARS < 8) ? MAX_LABEL_CHARS : 8;
   localparam int REC_DEPTH = 2;

   localparam logic [7:0] BYTE_LF  = 8'h0A;
   localparam logic [7:0] BYTE_CR  = 8'h0D;
   localparam logic [7:0] BYTE_SP  = 8'h20;
   localparam logic [7:0] BYTE_D0  = 8'h30;
   localparam logic [7:0] BYTE_D9  = 8'h39;
   localparam logic [5:0] SUM_MASK = 6'h3F;
   localparam logic [VAL_W-1:0] VAL_MAX = '1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_MALFORMED = 2'd1;
   localparam logic [1:0] STATUS_CHECKSUM  = 2'd2;

   localparam logic [3:0] LBL_UNKNOWN = 4'd0;
   localparam logic [3:0] LBL_OPTARIF = 4'd15;
   localparam int         LBL_COUNT   = 15;

   localparam logic [2:0] TARIFF_NONE = 3'd0;
   localparam logic [2:0] TARIFF_BASE = 3'd1;
   localparam logic [2:0] TARIFF_HC   = 3'd2;
   localparam logic [2:0] TARIFF_EJP  = 3'd3;
   localparam logic [2:0] TARIFF_BBR  = 3'd4;

   typedef logic [MAX_LABEL_CHARS-1:0][7:0] migp_label_type;
   typedef logic [HEAD_LEN-1:0][7:0]        migp_head_type;

   // One closed group, handed from the parser to the result stage
   typedef struct packed {
      logic [1:0]           status;
      logic [LBL_CNT_W-1:0] label_count;
      migp_label_type       label_chars;
      logic [DAT_CNT_W-1:0] data_count;
      migp_head_type        data_head;
      logic [VAL_W-1:0]     reading;
   } migp_rec_type;

   typedef struct packed {
      logic [3:0]    len;
      logic [0:7][7:0] text;
   } migp_name_type;

   function automatic migp_name_type migp_label_entry(input logic [3:0] code);
      migp_name_type e;
      e.len  = 4'd0;
      e.text = '0;
      unique case (code)
         4'd1:    begin e.len = 4'd4; e.text = {"ADCO",    32'h0}; end
         4'd2:    begin e.len = 4'd4; e.text = {"BASE",    32'h0}; end
         4'd3:    begin e.len = 4'd4; e.text = {"HCHP",    32'h0}; end
         4'd4:    begin e.len = 4'd4; e.text = {"HCHC",    32'h0}; end
         4'd5:    begin e.len = 4'd5; e.text = {"EJPHN",   24'h0}; end
         4'd6:    begin e.len = 4'd6; e.text = {"EJPHPM",  16'h0}; end
         4'd7:    begin e.len = 4'd7; e.text = {"BBRHPJB",  8'h0}; end
         4'd8:    begin e.len = 4'd7; e.text = {"BBRHPJW",  8'h0}; end
         4'd9:    begin e.len = 4'd7; e.text = {"BBRHPJR",  8'h0}; end
         4'd10:   begin e.len = 4'd7; e.text = {"BBRHCJB",  8'h0}; end
         4'd11:   begin e.len = 4'd7; e.text = {"BBRHCJW",  8'h0}; end
         4'd12:   begin e.len = 4'd7; e.text = {"BBRHCJR",  8'h0}; end
         4'd13:   begin e.len = 4'd5; e.text = {"IINST",   24'h0}; end
         4'd14:   begin e.len = 4'd4; e.text = {"PAPP",    32'h0}; end
         4'd15:   begin e.len = 4'd7; e.text = {"OPTARIF",  8'h0}; end
         default: begin e.len = 4'd0; e.text = '0; end
      endcase
      return e;
   endfunction

   function automatic logic [3:0] migp_match_label(input migp_label_type chars,
                                                   input logic [LBL_CNT_W-1:0] cnt);
      migp_name_type e;
      logic          same;
      logic [3:0]    code;
      code = LBL_UNKNOWN;
      // Scan downward so the lowest matching code wins
      for (int k = LBL_COUNT; k >= 1; k--) begin
         e    = migp_label_entry(4'(k));
         same = (32'(e.len) == 32'(cnt));
         for (int i = 0; i < LBL_CMP; i++) begin
            if ((i < 32'(e.len)) && (chars[i] != e.text[i])) begin
               same = 1'b0;
            end
         end
         if (same) begin
            code = 4'(k);
         end
      end
      return code;
   endfunction

   function automatic logic [2:0] migp_tariff(input migp_head_type head,
                                              input logic [DAT_CNT_W-1:0] cnt);
      logic exact4;
      logic bbr;
      logic [2:0] t;
      exact4 = (32'(cnt) == 4);
      bbr    = (32'(cnt) >= 3) && (head[0] == "B") && (head[1] == "B") && (head[2] == "R");
      priority if (exact4 && head[0] == "B" && head[1] == "A" && head[2] == "S"
                   && head[3] == "E") begin
         t = TARIFF_BASE;
      end else if (exact4 && head[0] == "H" && head[1] == "C" && head[2] == "."
                   && head[3] == ".") begin
         t = TARIFF_HC;
      end else if (exact4 && head[0] == "E" && head[1] == "J" && head[2] == "P"
                   && head[3] == ".") begin
         t = TARIFF_EJP;
      end else if (bbr) begin
         t = TARIFF_BBR;
      end else begin
         t = TARIFF_NONE;
      end
      return t;
   endfunction

endpackage

// ===== src/migp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// migp_front
// Byte parser: tracks the group phase, collects label and data head, sums the
// checked bytes and converts leading digits; posts one record per closed group.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
module migp_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_accept,
   input  logic [7:0]            in_byte,
   output logic                  rec_push,
   output migp_pkg::migp_rec_type rec_data
);
   import migp_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_LABEL,
      PH_DATA,
      PH_CHECK,
      PH_END,
      PH_BAD
   } phase_type;

   phase_type            phase_ff, phase_in;
   migp_label_type       label_chars_ff;
   logic [LBL_CNT_W-1:0] label_count_ff, label_count_in;
   migp_head_type        data_head_ff;
   logic [DAT_CNT_W-1:0] data_count_ff, data_count_in;
   logic [5:0]           sum_ff, sum_in;
   logic [VAL_W-1:0]     value_ff, value_in;
   logic                 digits_ff, digits_in;
   logic [7:0]           check_ff, check_in;

   logic                 label_we;
   logic                 head_we;
   logic [DAT_CNT_W+1:0] dcnt_ext;
   logic                 is_digit;
   logic [VAL_W+3:0]     val_ext;
   logic [VAL_W+3:0]     val_next;
   logic                 check_ok;
   logic [1:0]           emit_status;

   assign dcnt_ext = (DAT_CNT_W + 2)'(data_count_ff);
   assign is_digit = (in_byte >= BYTE_D0) && (in_byte <= BYTE_D9);
   assign val_ext  = (VAL_W + 4)'(value_ff);
   // value * 10 + digit, at most 44 bits
   assign val_next = (val_ext << 3) + (val_ext << 1) + (VAL_W + 4)'(in_byte[3:0]);
   assign check_ok = (({2'b00, sum_ff} + BYTE_SP) == check_ff);

   always_comb begin
      phase_in       = phase_ff;
      label_count_in = label_count_ff;
      data_count_in  = data_count_ff;
      sum_in         = sum_ff;
      value_in       = value_ff;
      digits_in      = digits_ff;
      check_in       = check_ff;
      label_we       = 1'b0;
      head_we        = 1'b0;
      rec_push       = 1'b0;
      emit_status    = STATUS_MALFORMED;
      if (in_accept) begin
         if (in_byte == BYTE_LF) begin
            phase_in       = PH_LABEL;
            label_count_in = '0;
            data_count_in  = '0;
            sum_in         = '0;
            value_in       = '0;
            digits_in      = 1'b1;
            check_in       = '0;
         end else begin
            unique case (phase_ff)
               PH_IDLE: begin
                  phase_in = PH_IDLE;
               end
               PH_LABEL: begin
                  if (in_byte == BYTE_CR) begin
                     rec_push = 1'b1;
                     phase_in = PH_IDLE;
                  end else if (in_byte == BYTE_SP) begin
                     if (label_count_ff == '0) begin
                        phase_in = PH_BAD;
                     end else begin
                        sum_in   = (sum_ff + BYTE_SP[5:0]) & SUM_MASK;
                        phase_in = PH_DATA;
                     end
                  end else if (32'(label_count_ff) >= MAX_LABEL_CHARS) begin
                     phase_in = PH_BAD;
                  end else begin
                     label_we       = 1'b1;
                     label_count_in = label_count_ff + 1'b1;
                     sum_in         = (sum_ff + in_byte[5:0]) & SUM_MASK;
                  end
               end
               PH_DATA: begin
                  if (in_byte == BYTE_CR) begin
                     rec_push = 1'b1;
                     phase_in = PH_IDLE;
                  end else if (in_byte == BYTE_SP) begin
                     phase_in = (data_count_ff == '0) ? PH_BAD : PH_CHECK;
                  end else if (32'(data_count_ff) >= MAX_DATA_CHARS) begin
                     phase_in = PH_BAD;
                  end else begin
                     head_we       = (32'(data_count_ff) < HEAD_LEN);
                     data_count_in = data_count_ff + 1'b1;
                     sum_in        = (sum_ff + in_byte[5:0]) & SUM_MASK;
                     if (digits_ff && is_digit) begin
                        // saturate once the value leaves forty bits
                        value_in = (val_next > (VAL_W + 4)'(VAL_MAX)) ? VAL_MAX
                                                                     : val_next[VAL_W-1:0];
                     end else begin
                        digits_in = 1'b0;
                     end
                  end
               end
               PH_CHECK: begin
                  if (in_byte == BYTE_CR) begin
                     rec_push = 1'b1;
                     phase_in = PH_IDLE;
                  end else begin
                     check_in = in_byte;
                     phase_in = PH_END;
                  end
               end
               PH_END: begin
                  if (in_byte != BYTE_CR) begin
                     phase_in = PH_BAD;
                  end else begin
                     rec_push    = 1'b1;
                     emit_status = check_ok ? STATUS_OK : STATUS_CHECKSUM;
                     phase_in    = PH_IDLE;
                  end
               end
               PH_BAD: begin
                  if (in_byte == BYTE_CR) begin
                     rec_push = 1'b1;
                     phase_in = PH_IDLE;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   always_comb begin
      rec_data.status      = emit_status;
      rec_data.label_count = label_count_ff;
      rec_data.label_chars = label_chars_ff;
      rec_data.data_count  = data_count_ff;
      rec_data.data_head   = data_head_ff;
      rec_data.reading     = value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         label_count_ff <= '0;
         data_count_ff  <= '0;
         sum_ff         <= '0;
         value_ff       <= '0;
         digits_ff      <= 1'b1;
         check_ff       <= '0;
      end else begin
         phase_ff       <= phase_in;
         label_count_ff <= label_count_in;
         data_count_ff  <= data_count_in;
         sum_ff         <= sum_in;
         value_ff       <= value_in;
         digits_ff      <= digits_in;
         check_ff       <= check_in;
      end
      if (label_we) begin
         label_chars_ff[label_count_ff[LBL_IDX_W-1:0]] <= in_byte;
      end
      if (head_we) begin
         data_head_ff[dcnt_ext[1:0]] <= in_byte;
      end
   end

endmodule

// ===== src/migp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// migp_queue
// Short record queue between the parser and the result stage.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
module migp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_en,
   input  migp_pkg::migp_rec_type push_data,
   input  logic                   pop_en,
   output migp_pkg::migp_rec_type pop_data,
   output logic                   q_full,
   output logic                   q_empty
);
   import migp_pkg::*;

   localparam int PTR_W = (REC_DEPTH > 1) ? $clog2(REC_DEPTH) : 1;
   localparam int CNT_W = $clog2(REC_DEPTH + 1);

   migp_rec_type     entry_ff [REC_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign q_full   = (32'(count_ff) == REC_DEPTH);
   assign q_empty  = (count_ff == '0);
   assign do_push  = push_en && !q_full;
   assign do_pop   = pop_en && !q_empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == REC_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == REC_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      priority if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_en |-> !q_full)
      else $error("record pushed into a full queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= REC_DEPTH)
      else $error("record queue count out of range");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("record queue count did not advance on push");
`endif

endmodule

// ===== src/migp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// migp_back
// Result stage: matches the label, decodes the tariff option and holds the
// finished result in an output register until it is popped.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
module migp_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   rec_empty,
   input  migp_pkg::migp_rec_type rec_head,
   output logic                   rec_pop,
   input  logic                   out_pop,
   output logic                   out_empty,
   output logic [1:0]             out_status,
   output logic [3:0]             out_label_code,
   output logic [39:0]            out_reading,
   output logic [2:0]             out_tariff_option
);
   import migp_pkg::*;

   logic             valid_ff;
   logic [1:0]       status_ff;
   logic [3:0]       code_ff;
   logic [VAL_W-1:0] reading_ff;
   logic [2:0]       tariff_ff;

   logic             load;
   logic             ok;
   logic [3:0]       code_c;
   logic [2:0]       tariff_c;

   assign load     = !rec_empty && (!valid_ff || out_pop);
   assign rec_pop  = load;
   assign ok       = (rec_head.status == STATUS_OK);
   assign code_c   = migp_match_label(rec_head.label_chars, rec_head.label_count);
   assign tariff_c = migp_tariff(rec_head.data_head, rec_head.data_count);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (out_pop) begin
         valid_ff <= 1'b0;
      end
      if (load) begin
         // failed groups carry no label, reading or tariff
         status_ff  <= rec_head.status;
         code_ff    <= ok ? code_c : LBL_UNKNOWN;
         reading_ff <= ok ? rec_head.reading : '0;
         tariff_ff  <= (ok && code_c == LBL_OPTARIF) ? tariff_c : TARIFF_NONE;
      end
   end

   assign out_empty         = !valid_ff;
   assign out_status        = status_ff;
   assign out_label_code    = code_ff;
   assign out_reading       = reading_ff;
   assign out_tariff_option = tariff_ff;

endmodule

// ===== src/meter_info_group_parser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// meter_info_group_parser_unit
// Parses metering groups (LF label SP data SP check CR) from a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Request side is a queue write port: drive req_rx_byte with push high; the
//   byte is taken on any edge where full is low. One byte per cycle is taken
//   while full is low; the parser keeps no per-byte backlog.
//   Response side is a queue read port: while empty is low the rsp_* ports
//   show the oldest result (status, label code, reading, tariff option);
//   pop takes it. A result exists only for a CR that closes a group.
//   Result path: the CR pushes a record into the record queue, and the
//   result stage then loads it into the output register.
//   A two-entry record queue and the output register decouple the parser
//   from the result stage, so up to three results may wait while pop is
//   low; full rises when both record queue entries are occupied.
//   Reset (synchronous, active high) puts the parser outside any group and
//   empties the queue and output register.
// ----------------------------------------------------------------------------
module meter_info_group_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_rx_byte,
   input  logic        pop,
   output logic        empty,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_label_code,
   output logic [39:0] rsp_reading,
   output logic [2:0]  rsp_tariff_option
);
   import migp_pkg::*;

   logic         accept;
   logic         rec_push;
   migp_rec_type rec_in;
   migp_rec_type rec_head;
   logic         rec_pop;
   logic         rec_full;
   logic         rec_empty;

   assign full   = rec_full;
   assign accept = push && !rec_full;

   migp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_accept (accept),
      .in_byte   (req_rx_byte),
      .rec_push  (rec_push),
      .rec_data  (rec_in)
   );

   migp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_en   (rec_push),
      .push_data (rec_in),
      .pop_en    (rec_pop),
      .pop_data  (rec_head),
      .q_full    (rec_full),
      .q_empty   (rec_empty)
   );

   migp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .rec_empty         (rec_empty),
      .rec_head          (rec_head),
      .rec_pop           (rec_pop),
      .out_pop           (pop),
      .out_empty         (empty),
      .out_status        (rsp_status),
      .out_label_code    (rsp_label_code),
      .out_reading       (rsp_reading),
      .out_tariff_option (rsp_tariff_option)
   );

endmodule
